// File: sv/signed_fixed_decimal_to_ascii_macros.svh
// assertion macros for the decimal formatter
// each check samples on the rising edge of clk and is off while rst_n is low
`ifndef SIGNED_FIXED_DECIMAL_TO_ASCII_MACROS_SVH
`define SIGNED_FIXED_DECIMAL_TO_ASCII_MACROS_SVH
`ifndef ASSERT_OFF
`define SFDA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sfda assertion failed");
`define SFDA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfda implication failed");
`define SFDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfda next-cycle check failed");
`else
`define SFDA_ASSERT(label, prop)
`define SFDA_ASSERT_IMPLY(label, ante, cons)
`define SFDA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: sv/sfda_pkg.sv
`default_nettype none
package sfda_pkg;

    // one bcd digit held by a cell
    typedef logic [3:0] digit_t;

    // per-cycle command to every digit cell
    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } sfda_cell_ctrl_t;

    // ascii codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // a digit of five or more spills a one into the next cell on the shift
    function automatic logic carry_of(input digit_t d);
        return (d >= 4'd5);
    endfunction

endpackage
`default_nettype wire

// File: sv/sfda_cell.sv
`default_nettype none
module sfda_cell (
    input  wire                        clk,
    input  wire                        rst_n,
    input  sfda_pkg::sfda_cell_ctrl_t  ctrl,
    input  wire                        bit_in,
    input  sfda_pkg::digit_t           digit_in,
    output sfda_pkg::digit_t           digit
);

    sfda_pkg::digit_t digit_reg;
    sfda_pkg::digit_t adj;
    sfda_pkg::digit_t digit_next;

    // add three when the digit would overflow on doubling
    assign adj = sfda_pkg::carry_of(digit_reg) ? 4'(digit_reg + 4'd3) : digit_reg;

    // clear on a new request, double-dabble during conversion, move up when emitting
    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[2:0], bit_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule
`default_nettype wire

// File: sv/signed_fixed_decimal_to_ascii.sv
// the sign is shown on strobe in the cycle after start is taken, and the digits follow the
// conversion; busy stays high through the conversion, the emission and any point
// a new request is taken only while busy is low; start is ignored while busy
// the conversion is one double-dabble shift per cycle through a row of bcd cells
// leading zeros are skipped, then one character per cycle
// rst_n clears the sequencer and the strobe asynchronously; busy drops as the last is shown
`default_nettype none
`include "signed_fixed_decimal_to_ascii_macros.svh"
module signed_fixed_decimal_to_ascii #(
    parameter int MAX_DECIMALS = 20,
    parameter int VALUE_BITS   = 64
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    output logic              busy,
    input  wire signed [63:0] value,
    input  wire        [4:0]  decimals,
    output logic              strobe,
    output logic       [7:0]  char_code,
    output logic              last
);

    localparam int DEC_LIMIT  = (MAX_DECIMALS < 20) ? MAX_DECIMALS : 20;
    localparam int MAG_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int CELLS      = (MAG_DIGITS > DEC_LIMIT + 1) ? MAG_DIGITS : DEC_LIMIT + 1;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int POS_W      = $clog2(CELLS);
    localparam int CMP_W      = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT,
        ST_POINT
    } state_t;

    state_t                   state_reg;
    logic [VALUE_BITS-1:0]    mag_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [4:0]               dec_reg;
    logic                     started_reg;
    logic                     strobe_reg;
    logic [7:0]               char_reg;
    logic                     last_reg;

    logic [VALUE_BITS-1:0]    raw;
    logic                     neg;
    logic [VALUE_BITS-1:0]    mag_in;
    logic [4:0]               dec_in;
    logic                     accept;
    sfda_pkg::sfda_cell_ctrl_t ctrl;
    sfda_pkg::digit_t         digits [CELLS];
    logic                     carry [CELLS];
    sfda_pkg::digit_t         top_digit;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         dec_ext;
    logic                     skip;
    logic                     in_convert;
    logic                     sign_shown;
    logic                     point_shown;

    // magnitude as unsigned so the most negative value prints exactly
    assign raw    = value[VALUE_BITS-1:0];
    assign neg    = raw[VALUE_BITS-1];
    assign mag_in = neg ? VALUE_BITS'(~raw + 1'b1) : raw;
    assign dec_in = (decimals > 5'(DEC_LIMIT)) ? 5'(DEC_LIMIT) : decimals;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // cell commands
    assign ctrl.clear  = accept;
    assign ctrl.dabble = (state_reg == ST_CONVERT);
    assign ctrl.shift  = (state_reg == ST_EMIT);

    // row of bcd cells, lowest digit fed by the magnitude msb
    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign carry[i] = mag_reg[VALUE_BITS-1];
            sfda_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .bit_in   (carry[i]),
                .digit_in (4'd0),
                .digit    (digits[i])
            );
        end
        else
        begin : g_rest
            assign carry[i] = sfda_pkg::carry_of(digits[i-1]);
            sfda_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .bit_in   (carry[i]),
                .digit_in (digits[i-1]),
                .digit    (digits[i])
            );
        end
    end

    // leading zeros above the padded width are dropped
    assign top_digit = digits[CELLS-1];
    assign pos_ext   = CMP_W'(pos_reg);
    assign dec_ext   = CMP_W'(dec_reg);
    assign skip      = !started_reg && (top_digit == 4'd0) && (pos_ext > dec_ext);

    // sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mag_reg     <= '0;
            cnt_reg     <= '0;
            pos_reg     <= '0;
            dec_reg     <= '0;
            started_reg <= 1'b0;
            strobe_reg  <= 1'b0;
            char_reg    <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        mag_reg     <= mag_in;
                        cnt_reg     <= CNT_W'(VALUE_BITS - 1);
                        dec_reg     <= dec_in;
                        started_reg <= 1'b0;
                        strobe_reg  <= 1'b1;
                        char_reg    <= neg ? sfda_pkg::CH_MINUS : sfda_pkg::CH_PLUS;
                        state_reg   <= ST_CONVERT;
                    end
                end
                ST_CONVERT:
                begin
                    mag_reg <= {mag_reg[VALUE_BITS-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        pos_reg   <= POS_W'(CELLS - 1);
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    pos_reg <= pos_reg - 1'b1;
                    if (!skip)
                    begin
                        strobe_reg  <= 1'b1;
                        char_reg    <= sfda_pkg::CH_ZERO | {4'd0, top_digit};
                        started_reg <= 1'b1;
                        if (pos_reg == '0)
                        begin
                            last_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else if ((dec_reg != '0) && (pos_ext == dec_ext))
                        begin
                            state_reg <= ST_POINT;
                        end
                    end
                end
                ST_POINT:
                begin
                    strobe_reg <= 1'b1;
                    char_reg   <= sfda_pkg::CH_POINT;
                    state_reg  <= ST_EMIT;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

    // terms for the checks
    assign in_convert  = (state_reg == ST_CONVERT);
    assign sign_shown  = strobe &&
                         ((char_code == sfda_pkg::CH_PLUS) || (char_code == sfda_pkg::CH_MINUS));
    assign point_shown = strobe && (char_code == sfda_pkg::CH_POINT) && !last;

    // checks
    `SFDA_ASSERT_IMPLY(a_last_has_strobe, last, strobe)
    `SFDA_ASSERT_IMPLY(a_last_ends_request, strobe && last, state_reg == ST_IDLE)
    `SFDA_ASSERT_NEXT(a_sign_first, accept, sign_shown)
    `SFDA_ASSERT_IMPLY(a_quiet_convert, in_convert && $past(in_convert), !strobe)
    `SFDA_ASSERT_NEXT(a_point_then_digit, state_reg == ST_POINT, point_shown)

endmodule
`default_nettype wire
